>>> design/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// shared types, constants and the crc-16 byte fold for the picture hash checker
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

    // coordinate width of col and row
    localparam int PHC_COORD_BITS = 13;

    // work queue geometry
    localparam int PHC_Q_AW    = 2;
    localparam int PHC_Q_DEPTH = 1 << PHC_Q_AW;

    // hash constants
    localparam logic [15:0] PHC_CRC_INIT  = 16'hFFFF;
    localparam logic [31:0] PHC_SUM_INIT  = 32'h0000_0000;

    // hash mode codes
    localparam logic PHC_MODE_CRC = 1'b0;
    localparam logic PHC_MODE_SUM = 1'b1;

    // one crc-16 byte fold, polynomial 0x1021, msb first
    function automatic logic [15:0] phc_crc_fold(logic [15:0] crc, logic [7:0] data);
        logic [7:0]  s;
        logic [7:0]  t;
        logic [15:0] t16;
        s   = data ^ crc[15:8];
        t   = s ^ (s >> 4);
        t16 = {8'h00, t};
        return {crc[7:0], 8'h00} ^ t16 ^ (t16 << 5) ^ (t16 << 12);
    endfunction

    // crc value after plane start: init, then two zero bytes folded in
    localparam logic [15:0] PHC_CRC_START =
        phc_crc_fold(phc_crc_fold(PHC_CRC_INIT, 8'h00), 8'h00);

    // one classified sample on its way from front to back
    typedef struct packed {
        logic [7:0]  sample;
        logic [7:0]  term;
        logic        first_of_plane;
        logic        last_of_plane;
        logic [31:0] expected_hash;
    } t_work;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

`default_nettype wire

>>> design/phc_if.sv
// ----------------------------------------------------------------------------
// phc_if
// valid/ready channels for samples in and hash results out
// ----------------------------------------------------------------------------
`default_nettype none

interface phc_in_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        sample;
    logic [phc_pkg::PHC_COORD_BITS-1:0] col;
    logic [phc_pkg::PHC_COORD_BITS-1:0] row;
    logic                              first_of_plane;
    logic                              last_of_plane;
    logic [31:0]                       expected_hash;

    modport source (
        output valid, sample, col, row, first_of_plane, last_of_plane, expected_hash,
        input  ready
    );
    modport sink (
        input  valid, sample, col, row, first_of_plane, last_of_plane, expected_hash,
        output ready
    );
endinterface

interface phc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] computed_hash;
    logic        match;

    modport source (
        output valid, computed_hash, match,
        input  ready
    );
    modport sink (
        input  valid, computed_hash, match,
        output ready
    );
endinterface

`default_nettype wire

>>> design/phc_front.sv
// ----------------------------------------------------------------------------
// phc_front
// accepts samples, forms the xor-masked checksum term and pushes work entries
// ----------------------------------------------------------------------------
`default_nettype none

module phc_front (
    phc_in_if.sink            i_in,
    input  phc_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output phc_pkg::t_work    o_push_item
);

    logic [7:0] w_col_lo;
    logic [7:0] w_row_lo;
    logic [7:0] w_col_hi;
    logic [7:0] w_row_hi;
    logic [7:0] w_mask;

    // take a sample whenever the queue has room
    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    // coordinate mask: low bytes and high parts of col and row
    always_comb begin
        w_col_lo = i_in.col[7:0];
        w_row_lo = i_in.row[7:0];
        w_col_hi = 8'(i_in.col >> 8);
        w_row_hi = 8'(i_in.row >> 8);
        w_mask   = w_col_lo ^ w_row_lo ^ w_col_hi ^ w_row_hi;
    end

    // work entry for the back end
    always_comb begin
        o_push_item.sample         = i_in.sample;
        o_push_item.term           = i_in.sample ^ w_mask;
        o_push_item.first_of_plane = i_in.first_of_plane;
        o_push_item.last_of_plane  = i_in.last_of_plane;
        o_push_item.expected_hash  = i_in.expected_hash;
    end

endmodule

`default_nettype wire

>>> design/phc_queue.sv
// ----------------------------------------------------------------------------
// phc_queue
// short fifo of work entries between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module phc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  phc_pkg::t_work    i_push_item,
    input  logic              i_pop,
    output phc_pkg::t_work    o_head,
    output phc_pkg::t_q_stat  o_stat
);

    phc_pkg::t_work              r_mem [phc_pkg::PHC_Q_DEPTH];
    logic [phc_pkg::PHC_Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [phc_pkg::PHC_Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [phc_pkg::PHC_Q_AW:0]   r_count,  n_count;

    // status
    always_comb begin
        o_stat.full     = (r_count == (phc_pkg::PHC_Q_AW + 1)'(phc_pkg::PHC_Q_DEPTH));
        o_stat.nonempty = (r_count != '0);
    end

    assign o_head = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? 1'b1 : 1'b0);
        n_rd_ptr = r_rd_ptr + (i_pop  ? 1'b1 : 1'b0);
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

>>> design/phc_back.sv
// ----------------------------------------------------------------------------
// phc_back
// folds work entries into the crc and checksum registers and emits results
// ----------------------------------------------------------------------------
`default_nettype none

module phc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_hash_mode,
    input  phc_pkg::t_work    i_head,
    input  phc_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    phc_out_if.source         o_result
);

    logic [15:0] r_crc, n_crc;
    logic [31:0] r_sum, n_sum;
    logic        r_valid, n_valid;
    logic [31:0] r_hash, n_hash;
    logic        r_match, n_match;
    logic [15:0] w_crc_base;
    logic [31:0] w_sum_base;
    logic        w_out_free;

    // the result register is free when empty or being taken this cycle
    assign w_out_free = !r_valid || o_result.ready;
    assign o_pop      = i_q_stat.nonempty && (!i_head.last_of_plane || w_out_free);

    // hash update, restarting at plane start
    always_comb begin
        w_crc_base = i_head.first_of_plane ? phc_pkg::PHC_CRC_START : r_crc;
        w_sum_base = i_head.first_of_plane ? phc_pkg::PHC_SUM_INIT  : r_sum;
        n_crc      = r_crc;
        n_sum      = r_sum;
        if (o_pop) begin
            n_crc = phc_pkg::phc_crc_fold(w_crc_base, i_head.sample);
            n_sum = w_sum_base + {24'h000000, i_head.term};
        end
    end

    // result register
    always_comb begin
        n_valid = r_valid && !o_result.ready;
        n_hash  = r_hash;
        n_match = r_match;
        if (o_pop && i_head.last_of_plane) begin
            n_valid = 1'b1;
            if (i_hash_mode == phc_pkg::PHC_MODE_CRC) begin
                n_hash  = {16'h0000, n_crc};
                n_match = (n_crc == i_head.expected_hash[15:0]);
            end else begin
                n_hash  = n_sum;
                n_match = (n_sum == i_head.expected_hash);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= phc_pkg::PHC_CRC_INIT;
            r_sum   <= phc_pkg::PHC_SUM_INIT;
            r_valid <= 1'b0;
        end else begin
            r_crc   <= n_crc;
            r_sum   <= n_sum;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash  <= n_hash;
        r_match <= n_match;
    end

    assign o_result.valid         = r_valid;
    assign o_result.computed_hash = r_hash;
    assign o_result.match         = r_match;

endmodule

`default_nettype wire

>>> design/picture_hash_checker_top.sv
// ----------------------------------------------------------------------------
// picture_hash_checker_top
// decoded picture hash check (crc-16 or xor-masked checksum) for 8-bit planes
// ----------------------------------------------------------------------------
// channel    dir  transfer      payload
// i_in       in   valid/ready   sample, col, row, first/last_of_plane, expected_hash
// o_result   out  valid/ready   computed_hash, match
// i_cfg_*    in   write enable  hash_mode
//
// one sample per cycle sustained while the queue has room; the crc/sum update loop in
// phc_back folds one byte per cycle while it pops. a result passes through the queue
// and the result register after its last sample is taken. reset is synchronous: crc
// goes to 0xffff, sum and hash_mode to 0, queue empty. a stalled result holds the
// back end only on the next last sample; the 4-entry queue absorbs samples meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module picture_hash_checker_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    phc_in_if.sink    i_in,
    phc_out_if.source o_result
);

    logic              r_hash_mode;
    logic              w_push;
    phc_pkg::t_work    w_push_item;
    logic              w_pop;
    phc_pkg::t_work    w_head;
    phc_pkg::t_q_stat  w_q_stat;

    // hash mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode <= phc_pkg::PHC_MODE_CRC;
        end else if (i_cfg_we) begin
            r_hash_mode <= i_cfg_wdata;
        end
    end

    // front end
    phc_front u_front (
        .i_in        (i_in),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    // work queue
    phc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // back end
    phc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hash_mode (r_hash_mode),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_result    (o_result)
    );

    // a result only appears after a last sample left the queue
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_pop && w_head.last_of_plane))
        else $error("result raised without a last sample");

    // a waiting result is never overwritten by the next plane
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |-> !(w_pop && w_head.last_of_plane))
        else $error("pending result overwritten");

    // a pushed entry is in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> w_q_stat.nonempty)
        else $error("pushed entry lost");

    // never pop from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.nonempty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for picture_hash_checker_top: drives sample transfers
// plane by plane, predicts the crc-16 and the masked 32-bit checksum of each
// plane, and compares every result transfer against the oldest prediction
// ----------------------------------------------------------------------------

module tb;

    localparam int CB           = phc_pkg::PHC_COORD_BITS;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_CYCLES   = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int MODE_SWAP_AT = 140;

    typedef struct packed {
        logic [31:0] hash;
        logic        match;
    } t_plane_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    phc_in_if  in_ch ();
    phc_out_if res_ch ();

    picture_hash_checker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_result    (res_ch)
    );

    // predicted plane state and the hash mode it reports in
    logic [15:0]   plane_crc;
    logic [31:0]   plane_sum;
    logic          hash_mode_sel;
    t_plane_result pending_hashes[$];
    t_plane_result oldest_hash;

    int error_count   = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int rx_hold_req   = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_hashes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one crc-16 byte, polynomial 0x1021, msb first, bit by bit
    function automatic logic [15:0] crc16_fold_byte(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    // crc at plane start: all ones, then two zero bytes
    function automatic logic [15:0] crc_after_start();
        return crc16_fold_byte(crc16_fold_byte(16'hFFFF, 8'h00), 8'h00);
    endfunction

    // result side: ready pattern, with long hold-offs on request
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            res_ch.ready <= 1'b0;
            rx_hold_req = rx_hold_req - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_hashes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: hash %08h match %0b",
                             $realtime, res_ch.computed_hash, res_ch.match);
            end else begin
                oldest_hash = pending_hashes.pop_front();
                if (res_ch.computed_hash !== oldest_hash.hash ||
                    res_ch.match !== oldest_hash.match) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: hash %08h match %0b, expected hash %08h match %0b",
                                 $realtime, res_ch.computed_hash, res_ch.match,
                                 oldest_hash.hash, oldest_hash.match);
                end
            end
        end
    end

    // predict one sample, then drive its transfer with random gaps
    task automatic send_sample(input logic [7:0] smp, input logic [CB-1:0] c,
                               input logic [CB-1:0] r, input logic fst, input logic lst,
                               input logic [31:0] hash_seed, input bit want_match);
        logic [15:0]   crc_n;
        logic [31:0]   sum_n;
        logic [7:0]    mask;
        logic [31:0]   exp_hash;
        t_plane_result res;
        crc_n = fst ? crc_after_start() : plane_crc;
        crc_n = crc16_fold_byte(crc_n, smp);
        sum_n = fst ? 32'h0 : plane_sum;
        mask  = c[7:0] ^ r[7:0] ^ 8'(c >> 8) ^ 8'(r >> 8);
        sum_n = sum_n + {24'h0, smp ^ mask};
        exp_hash = hash_seed;
        if (lst) begin
            if (hash_mode_sel == phc_pkg::PHC_MODE_CRC) begin
                // only the low half takes part in the compare
                if (want_match)
                    exp_hash[15:0] = crc_n;
                res.hash  = {16'h0, crc_n};
                res.match = (exp_hash[15:0] == crc_n);
            end else begin
                if (want_match)
                    exp_hash = sum_n;
                res.hash  = sum_n;
                res.match = (exp_hash == sum_n);
            end
            pending_hashes.push_back(res);
        end
        plane_crc = crc_n;
        plane_sum = sum_n;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.sample         <= smp;
        in_ch.col            <= c;
        in_ch.row            <= r;
        in_ch.first_of_plane <= fst;
        in_ch.last_of_plane  <= lst;
        in_ch.expected_hash  <= exp_hash;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // stop sending and wait until the block has nothing left to give
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // hash mode write, only while drained
    task automatic write_hash_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= mode;
        hash_mode_sel = mode;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    // one plane in raster order, start and end markers optional
    task automatic send_plane(input int w, input int h, input bit with_start,
                              input bit with_end);
        logic [CB-1:0] c0;
        logic [CB-1:0] r0;
        c0 = $urandom_range(1) ? '0 : CB'($urandom_range((1 << CB) - w));
        r0 = $urandom_range(1) ? '0 : CB'($urandom_range((1 << CB) - h));
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                send_sample(8'($urandom_range(255)), CB'(c0 + x), CB'(r0 + y),
                            with_start && x == 0 && y == 0,
                            with_end && x == w - 1 && y == h - 1,
                            $urandom, 1'($urandom_range(1)));
            end
        end
    endtask

    // samples before any plane start continue from the reset values
    task automatic test_start_after_reset();
        write_hash_mode(phc_pkg::PHC_MODE_CRC);
        send_sample(8'h00, '0, '0, 1'b0, 1'b0, 32'h0, 1'b0);
        send_sample(8'hFF, '1, '1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        drain_results();
        write_hash_mode(phc_pkg::PHC_MODE_SUM);
        send_sample(8'hA5, CB'(13'h1F00), CB'(13'h00FF), 1'b0, 1'b1, 32'h0, 1'b1);
        drain_results();
    endtask

    // start and end on the same sample, crc compare ignoring the upper half
    task automatic test_one_sample_plane();
        send_sample(8'hFF, '1, '1, 1'b1, 1'b1, 32'h0, 1'b1);
        send_sample(8'h00, '0, '0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        drain_results();
        write_hash_mode(phc_pkg::PHC_MODE_CRC);
        send_sample(8'h00, '0, '0, 1'b1, 1'b1, 32'hFFFF_0000, 1'b1);
        send_sample(8'h80, CB'(13'h0100), '0, 1'b1, 1'b1, 32'h0, 1'b0);
        drain_results();
    endtask

    // mode written in the middle of a plane only picks the reported hash
    task automatic test_mode_switch_in_plane();
        send_sample(8'h12, CB'(0), '0, 1'b1, 1'b0, $urandom, 1'b0);
        send_sample(8'h34, CB'(1), '0, 1'b0, 1'b0, $urandom, 1'b0);
        drain_results();
        write_hash_mode(phc_pkg::PHC_MODE_SUM);
        send_sample(8'h56, CB'(2), '0, 1'b0, 1'b0, $urandom, 1'b0);
        send_sample(8'h78, CB'(3), '0, 1'b0, 1'b1, $urandom, 1'b1);
        send_sample(8'h9A, '0, CB'(5), 1'b1, 1'b0, $urandom, 1'b0);
        drain_results();
        write_hash_mode(phc_pkg::PHC_MODE_CRC);
        send_sample(8'hBC, CB'(1), CB'(5), 1'b0, 1'b1, $urandom, 1'b1);
        drain_results();
    endtask

    // a result leaves both hashes running
    task automatic test_result_keeps_state();
        send_sample(8'h11, CB'(0), '0, 1'b1, 1'b1, $urandom, 1'b1);
        send_sample(8'h22, CB'(1), '0, 1'b0, 1'b1, $urandom, 1'b1);
        send_sample(8'h33, CB'(2), '0, 1'b0, 1'b0, $urandom, 1'b0);
        send_sample(8'h44, CB'(3), '0, 1'b0, 1'b1, $urandom, 1'b0);
        drain_results();
    endtask

    // result side held off while one-sample planes keep coming
    task automatic test_full_stall();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        rx_hold_req   = 150;
        for (int i = 0; i < 12; i++)
            send_sample(8'($urandom_range(255)), CB'($urandom), CB'($urandom),
                        1'b1, 1'b1, $urandom, 1'($urandom_range(1)));
        drain_results();
    endtask

    // mostly well-formed planes, some stray samples and broken planes
    task automatic test_random_planes(input int n_items, input int src_pct,
                                      input int sink_pct);
        int start_count;
        int last_swap;
        int pick;
        int w;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start_count   = items_sent;
        last_swap     = items_sent;
        while (items_sent - start_count < n_items) begin
            pick = $urandom_range(99);
            w    = (pick < 5) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            if (pick < 78)
                send_plane(w, $urandom_range(1, 4), 1'b1, 1'b1);
            else if (pick < 88)
                send_sample(8'($urandom_range(255)), CB'($urandom), CB'($urandom),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            $urandom, 1'($urandom_range(1)));
            else if (pick < 94)
                send_plane(w, $urandom_range(1, 3), 1'b0, 1'b1);
            else
                send_plane(w, $urandom_range(1, 3), 1'b1, 1'b0);
            if (items_sent - last_swap >= MODE_SWAP_AT) begin
                drain_results();
                write_hash_mode(1'($urandom_range(1)));
                last_swap = items_sent;
            end
        end
        drain_results();
    endtask

    // test sequence
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.sample          = '0;
        in_ch.col             = '0;
        in_ch.row             = '0;
        in_ch.first_of_plane  = 1'b0;
        in_ch.last_of_plane   = 1'b0;
        in_ch.expected_hash   = '0;
        res_ch.ready          = 1'b0;
        plane_crc             = 16'hFFFF;
        plane_sum             = 32'h0;
        hash_mode_sel         = phc_pkg::PHC_MODE_CRC;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        src_idle_pct  = 20;
        sink_idle_pct = 20;
        test_start_after_reset();
        test_one_sample_plane();
        test_mode_switch_in_plane();
        test_result_keeps_state();
        test_full_stall();
        test_random_planes(430, 29, 52);
        write_hash_mode(phc_pkg::PHC_MODE_SUM);
        test_random_planes(430, 52, 29);
        write_hash_mode(phc_pkg::PHC_MODE_CRC);
        test_random_planes(430, 0, 0);

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
